// ----- hw/rtl/gbn_pkg.sv -----
// Shared types and constants for the go-back-N sender.
// Holds sequence and window sizing, operation and register codes and the result type.
// Depends on nothing; every other file imports it.
package gbn_pkg;

    localparam int SEQ_BITS   = 20;
    localparam int BASE_BITS  = SEQ_BITS + 1;
    localparam int TIME_BITS  = 32;
    localparam int WINDOW_MAX = 64;
    localparam int SLOT_BITS  = $clog2(WINDOW_MAX);

    localparam int WIN_BITS     = 7;
    localparam int TIMEOUT_BITS = 16;
    localparam int CFG_BITS     = SEQ_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [WIN_BITS-1:0]     WIN_LIMIT       = WIN_BITS'(WINDOW_MAX);
    localparam logic [WIN_BITS-1:0]     WIN_RESET       = WIN_BITS'(25);
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET   = TIMEOUT_BITS'(10000);

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_ACK  = 2'd1,
        OP_SEND = 2'd2
    } op_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_WINDOW  = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_LAST    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic                 send_valid;
        logic [SEQ_BITS-1:0]  send_sequence;
        logic                 timed_out;
        logic [BASE_BITS-1:0] window_base;
        logic                 all_acknowledged;
    } result_t;

endpackage

// ----- hw/rtl/gbn_if.sv -----
// Handshake channels of the go-back-N sender: event beats in, result beats out.
// Depends on gbn_pkg for the field widths.
interface gbn_event_if;
    import gbn_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [SEQ_BITS-1:0] ack_expected;
    logic                ack_damaged;

    modport source (output valid, output operation, output ack_expected, output ack_damaged,
                    input ready);
    modport sink   (input valid, input operation, input ack_expected, input ack_damaged,
                    output ready);
endinterface

interface gbn_result_if;
    import gbn_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 send_valid;
    logic [SEQ_BITS-1:0]  send_sequence;
    logic                 timed_out;
    logic [BASE_BITS-1:0] window_base;
    logic                 all_acknowledged;

    modport source (output valid, output send_valid, output send_sequence, output timed_out,
                    output window_base, output all_acknowledged, input ready);
    modport sink   (input valid, input send_valid, input send_sequence, input timed_out,
                    input window_base, input all_acknowledged, output ready);
endinterface

// ----- hw/rtl/go_back_n_sender.sv -----
// Go-back-N sender top level: window state, timer, configuration and result path.
// Depends on gbn_pkg, gbn_if, gbn_deadline_ram and gbn_out_reg.
//
//  channel   direction  beat contents
//  events    in         operation, ack_expected, ack_damaged
//  results   out        send_valid, send_sequence, timed_out, window_base, all_acknowledged
//  cfg       in         cfg_we, cfg_index, cfg_data (write only)
//
// One event beat is taken per cycle; its result appears in the result register on the
// next cycle. All state updates are made in the cycle the beat is accepted.
// The deadline read on a timer rearm lands in the following cycle and is taken in as the timer
// deadline then, so it is already in force for the next event beat.
// Reset clears all control state and loads the register defaults; the deadline store
// needs no clearing. Events are held off only while a result waits and the sink stalls.
module go_back_n_sender
    import gbn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    gbn_event_if.sink               events,
    gbn_result_if.source            results,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    logic [WIN_BITS-1:0]     window_size_reg;
    logic [TIMEOUT_BITS-1:0] timeout_reg;
    logic [SEQ_BITS-1:0]     last_seq_reg;

    logic [BASE_BITS-1:0] oldest_reg,   oldest_next;
    logic [BASE_BITS-1:0] next_seq_reg, next_seq_next;
    logic [TIME_BITS-1:0] time_reg,     time_next;
    logic                 timer_on_reg, timer_on_next;
    logic [TIME_BITS-1:0] deadline_reg, deadline_next;
    logic                 reload_reg,   reload_next;

    logic                 accept;
    logic                 can_load;
    result_t              result;

    logic                 ram_we;
    logic [TIME_BITS-1:0] ram_wdata;
    logic [TIME_BITS-1:0] ram_rdata;

    logic [TIME_BITS-1:0] deadline_cur;
    logic [TIME_BITS-1:0] time_inc;
    logic [TIME_BITS-1:0] age;
    logic [BASE_BITS-1:0] ack_ext;
    logic [BASE_BITS-1:0] ack_clamped;
    logic [BASE_BITS-1:0] in_flight;
    logic [WIN_BITS-1:0]  win;
    logic                 sent;
    logic                 expired;

    assign events.ready = can_load;
    assign accept       = events.valid && can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= WIN_RESET;
            timeout_reg     <= TIMEOUT_RESET;
            last_seq_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW:  window_size_reg <= cfg_data[WIN_BITS-1:0];
                CFG_TIMEOUT: timeout_reg     <= cfg_data[TIMEOUT_BITS-1:0];
                CFG_LAST:    last_seq_reg    <= cfg_data[SEQ_BITS-1:0];
                default:     ;
            endcase
        end
    end

    // After a rearm the deadline comes straight from the store's read register.
    assign deadline_cur = reload_reg ? ram_rdata : deadline_reg;
    assign time_inc     = time_reg + TIME_BITS'(1);
    assign age          = time_inc - deadline_cur;
    assign ack_ext      = {1'b0, events.ack_expected};
    assign ack_clamped  = (ack_ext < next_seq_reg) ? ack_ext : next_seq_reg;
    assign in_flight    = next_seq_reg - oldest_reg;
    assign win          = (window_size_reg > WIN_LIMIT) ? WIN_LIMIT : window_size_reg;
    assign ram_wdata    = time_reg + {{(TIME_BITS-TIMEOUT_BITS){1'b0}}, timeout_reg};

    always_comb
    begin
        oldest_next   = oldest_reg;
        next_seq_next = next_seq_reg;
        time_next     = time_reg;
        timer_on_next = timer_on_reg;
        deadline_next = deadline_cur;
        reload_next   = 1'b0;
        ram_we        = 1'b0;
        sent          = 1'b0;
        expired       = 1'b0;
        if (accept)
        begin
            case (events.operation)
                OP_TICK:
                begin
                    time_next = time_inc;
                    // Wrap-safe compare: the deadline has passed when the age is small positive.
                    if (timer_on_reg && (age != '0) && !age[TIME_BITS-1])
                    begin
                        next_seq_next = oldest_reg;
                        timer_on_next = 1'b0;
                        expired       = 1'b1;
                    end
                end
                OP_ACK:
                begin
                    if (!events.ack_damaged && (ack_ext > oldest_reg))
                    begin
                        oldest_next = ack_clamped;
                        if (ack_clamped < next_seq_reg)
                        begin
                            reload_next   = 1'b1;
                            timer_on_next = 1'b1;
                        end
                        else
                        begin
                            timer_on_next = 1'b0;
                        end
                    end
                end
                OP_SEND:
                begin
                    if ((next_seq_reg <= {1'b0, last_seq_reg}) &&
                        (in_flight < {{(BASE_BITS-WIN_BITS){1'b0}}, win}))
                    begin
                        ram_we        = 1'b1;
                        sent          = 1'b1;
                        next_seq_next = next_seq_reg + BASE_BITS'(1);
                        if (!timer_on_reg)
                        begin
                            deadline_next = ram_wdata;
                            timer_on_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        result.send_valid       = sent;
        result.send_sequence    = sent ? next_seq_reg[SEQ_BITS-1:0] : '0;
        result.timed_out        = expired;
        result.window_base      = oldest_next;
        result.all_acknowledged = oldest_next > {1'b0, last_seq_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg   <= '0;
            next_seq_reg <= '0;
            time_reg     <= '0;
            timer_on_reg <= 1'b0;
            deadline_reg <= '0;
            reload_reg   <= 1'b0;
        end
        else
        begin
            oldest_reg   <= oldest_next;
            next_seq_reg <= next_seq_next;
            time_reg     <= time_next;
            timer_on_reg <= timer_on_next;
            deadline_reg <= deadline_next;
            reload_reg   <= reload_next;
        end
    end

    gbn_deadline_ram u_deadlines (
        .clk   (clk),
        .we    (ram_we),
        .waddr (next_seq_reg[SLOT_BITS-1:0]),
        .wdata (ram_wdata),
        .raddr (oldest_next[SLOT_BITS-1:0]),
        .rdata (ram_rdata)
    );

    gbn_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .data     (result),
        .can_load (can_load),
        .results  (results)
    );

endmodule

// ----- hw/rtl/gbn_deadline_ram.sv -----
// Per-slot packet deadline store, one write and one registered read per cycle.
// Depends on gbn_pkg for the slot count and time width.
module gbn_deadline_ram
    import gbn_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [SLOT_BITS-1:0] waddr,
    input  logic [TIME_BITS-1:0] wdata,
    input  logic [SLOT_BITS-1:0] raddr,
    output logic [TIME_BITS-1:0] rdata
);

    logic [TIME_BITS-1:0] mem [WINDOW_MAX];
    logic [TIME_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/gbn_out_reg.sv -----
// Result register between the sender logic and the result channel.
// Depends on gbn_pkg and the gbn_result_if interface.
module gbn_out_reg
    import gbn_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t data,
    output logic    can_load,
    gbn_result_if.source results
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // A new beat may enter whenever the held one is gone or leaves this cycle.
    assign can_load = !valid_reg || results.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= data;
        end
    end

    assign results.valid            = valid_reg;
    assign results.send_valid       = data_reg.send_valid;
    assign results.send_sequence    = data_reg.send_sequence;
    assign results.timed_out        = data_reg.timed_out;
    assign results.window_base      = data_reg.window_base;
    assign results.all_acknowledged = data_reg.all_acknowledged;

endmodule
